/* src/ptps_pkg.sv */
package ptps_pkg;

  localparam int unsigned GAIN_W     = 10;
  localparam int unsigned THR_W      = 30;
  localparam int unsigned LIM_W      = 30;
  localparam int unsigned CYC_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 30;

  localparam int unsigned SEC_W   = 32;
  localparam int unsigned NS_W    = 30;
  localparam int unsigned LOST_W  = 16;
  localparam int unsigned WHOLE_W = 6;
  localparam int unsigned FRAC_W  = 32;

  localparam int unsigned ERR_W   = NS_W + 1;
  localparam int unsigned PROD_W  = ERR_W + GAIN_W + 1;
  localparam int unsigned ACC_W   = PROD_W + 1;
  localparam int unsigned INTEG_W = 32;
  localparam int unsigned NSC_W   = 32;
  localparam int unsigned LNS_W   = LOST_W + CYC_W;

  localparam logic [NS_W-1:0]    NS_PER_SEC  = 30'd1000000000;
  localparam logic [WHOLE_W-1:0] PERIOD_FAST = 6'h20;
  localparam logic [WHOLE_W-1:0] PERIOD_SLOW = 6'h1F;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 10'd86;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 10'd2;
  localparam logic [THR_W-1:0]  THR_RST    = 30'd1000000;
  localparam logic [LIM_W-1:0]  LIM_RST    = 30'd500000000;
  localparam logic [CYC_W-1:0]  CYC_RST    = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_THRESHOLD = 3'd2,
    CFG_LIMIT     = 3'd3,
    CFG_CYCLE     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [THR_W-1:0]  thr;
    logic [LIM_W-1:0]  lim;
    logic [CYC_W-1:0]  cyc;
  } cfg_t;

  typedef struct packed {
    logic              do_step;
    logic [FRAC_W-1:0] fraction;
  } pi_res_t;

endpackage

/* src/ptp_clock_servo_pi.sv */
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   offset, now, lost_cycles
// out      output     out_valid_o / out_stall_i do_step, new time, period
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One word per cycle sustained while the output is not stalled.
// Input register, single-pass PI/step logic, result register; the integral
// updates as a word leaves the input register, so back-to-back words chain.
// Reset clears valids, the integral and loads default gains, threshold, limit and cycle.
// A stalled output holds; the input register still fills behind it.
module ptp_clock_servo_pi import ptps_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [SEC_W-1:0]     offset_seconds_i,
  input  logic        [NS_W-1:0]      offset_nanos_i,
  input  logic        [SEC_W-1:0]     now_seconds_i,
  input  logic        [NS_W-1:0]      now_nanos_i,
  input  logic        [LOST_W-1:0]    lost_cycles_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        do_step_o,
  output logic        [SEC_W-1:0]     new_seconds_o,
  output logic        [NS_W-1:0]      new_nanos_o,
  output logic        [WHOLE_W-1:0]   period_whole_ns_o,
  output logic        [FRAC_W-1:0]    period_fraction_o
);

  cfg_t cfg_q;

  logic                     s1_valid_q;
  logic signed [SEC_W-1:0]  off_s_q;
  logic        [NS_W-1:0]   off_ns_q;
  logic        [SEC_W-1:0]  now_s_q;
  logic        [NS_W-1:0]   now_ns_q;
  logic        [LOST_W-1:0] lost_q;

  logic                     out_valid_q;
  logic                     do_step_q;
  logic        [SEC_W-1:0]  new_s_q;
  logic        [NS_W-1:0]   new_ns_q;
  logic        [WHOLE_W-1:0] whole_q;
  logic        [FRAC_W-1:0] frac_q;

  logic                     out_free;
  logic                     adv;
  logic                     in_accept;
  logic        [SEC_W-1:0]  step_s;
  logic        [NS_W-1:0]   step_ns;
  pi_res_t                  pi_res;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p <= GAIN_P_RST;
      cfg_q.gain_i <= GAIN_I_RST;
      cfg_q.thr    <= THR_RST;
      cfg_q.lim    <= LIM_RST;
      cfg_q.cyc    <= CYC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_P:    cfg_q.gain_p <= cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_I:    cfg_q.gain_i <= cfg_wdata_i[GAIN_W-1:0];
        CFG_THRESHOLD: cfg_q.thr    <= cfg_wdata_i[THR_W-1:0];
        CFG_LIMIT:     cfg_q.lim    <= cfg_wdata_i[LIM_W-1:0];
        CFG_CYCLE:     cfg_q.cyc    <= cfg_wdata_i[CYC_W-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      off_s_q  <= offset_seconds_i;
      off_ns_q <= offset_nanos_i;
      now_s_q  <= now_seconds_i;
      now_ns_q <= now_nanos_i;
      lost_q   <= lost_cycles_i;
    end
  end

  ptps_step u_step (
    .offset_seconds_i (off_s_q),
    .offset_nanos_i   (off_ns_q),
    .now_seconds_i    (now_s_q),
    .now_nanos_i      (now_ns_q),
    .lost_cycles_i    (lost_q),
    .cycle_period_i   (cfg_q.cyc),
    .new_seconds_o    (step_s),
    .new_nanos_o      (step_ns)
  );

  ptps_pi u_pi (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .adv_i            (adv),
    .offset_seconds_i (off_s_q),
    .offset_nanos_i   (off_ns_q),
    .res_o            (pi_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      do_step_q <= pi_res.do_step;
      if (pi_res.do_step) begin
        new_s_q  <= step_s;
        new_ns_q <= step_ns;
        whole_q  <= '0;
        frac_q   <= '0;
      end else begin
        new_s_q  <= '0;
        new_ns_q <= '0;
        whole_q  <= pi_res.fraction[FRAC_W-1] ? PERIOD_SLOW : PERIOD_FAST;
        frac_q   <= pi_res.fraction;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign do_step_o         = do_step_q;
  assign new_seconds_o     = new_s_q;
  assign new_nanos_o       = new_ns_q;
  assign period_whole_ns_o = whole_q;
  assign period_fraction_o = frac_q;

  a_step_no_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && do_step_o |-> period_whole_ns_o == '0 && period_fraction_o == '0)
    else $error("step word carries a period");

  a_tune_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !do_step_o |->
      new_seconds_o == '0 && new_nanos_o == '0 &&
      period_whole_ns_o == (period_fraction_o[FRAC_W-1] ? PERIOD_SLOW : PERIOD_FAST))
    else $error("tune word inconsistent");

  a_free_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

/* src/ptps_step.sv */
module ptps_step import ptps_pkg::*; (
  input  logic signed [SEC_W-1:0]  offset_seconds_i,
  input  logic        [NS_W-1:0]   offset_nanos_i,
  input  logic        [SEC_W-1:0]  now_seconds_i,
  input  logic        [NS_W-1:0]   now_nanos_i,
  input  logic        [LOST_W-1:0] lost_cycles_i,
  input  logic        [CYC_W-1:0]  cycle_period_i,
  output logic        [SEC_W-1:0]  new_seconds_o,
  output logic        [NS_W-1:0]   new_nanos_o
);

  logic        [SEC_W-1:0] sec_diff;
  logic signed [NSC_W-1:0] ns_diff;
  logic signed [NSC_W-1:0] ns_borrow;
  logic signed [NSC_W-1:0] ns_lost;
  logic signed [NSC_W-1:0] ns_fix;
  logic        [LNS_W-1:0] lost_ns;
  logic                    borrow;
  logic                    carry;

  assign sec_diff = now_seconds_i - SEC_W'(offset_seconds_i);
  assign ns_diff  = $signed({2'b00, now_nanos_i}) - $signed({2'b00, offset_nanos_i});
  assign borrow   = ns_diff[NSC_W-1];
  assign ns_borrow = borrow ? (ns_diff + $signed({2'b00, NS_PER_SEC})) : ns_diff;
  assign lost_ns  = LNS_W'(lost_cycles_i) * LNS_W'(cycle_period_i);
  assign ns_lost  = ns_borrow + $signed(NSC_W'(lost_ns));
  assign carry    = ns_lost >= $signed({2'b00, NS_PER_SEC});
  assign ns_fix   = carry ? (ns_lost - $signed({2'b00, NS_PER_SEC})) : ns_lost;

  assign new_nanos_o   = ns_fix[NS_W-1:0];
  assign new_seconds_o = sec_diff - SEC_W'(borrow) + SEC_W'(carry);

endmodule

/* src/ptps_pi.sv */
module ptps_pi import ptps_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    adv_i,
  input  logic signed [SEC_W-1:0] offset_seconds_i,
  input  logic        [NS_W-1:0]  offset_nanos_i,
  output pi_res_t                 res_o
);

  logic signed [INTEG_W-1:0] integ_q;
  logic signed [INTEG_W-1:0] integ_d;

  logic                    sec_zero;
  logic                    sec_neg1;
  logic signed [ERR_W-1:0] err_pos;
  logic signed [ERR_W-1:0] err_neg;
  logic signed [ERR_W-1:0] mag;
  logic signed [ERR_W-1:0] err;
  logic                    do_step;

  logic signed [PROD_W-1:0] p_term;
  logic signed [PROD_W-1:0] i_term;
  logic signed [ACC_W-1:0]  acc_raw;
  logic signed [ACC_W-1:0]  lim_s;
  logic signed [ACC_W-1:0]  acc_sat;
  logic signed [ACC_W-1:0]  total;
  logic [ACC_W-FRAC_W:0]    total_hi;
  logic                     total_ovf;

  assign sec_zero = offset_seconds_i == '0;
  assign sec_neg1 = offset_seconds_i == '1;
  assign err_pos  = $signed({1'b0, NS_PER_SEC}) - $signed({1'b0, offset_nanos_i});
  assign err_neg  = -$signed({1'b0, offset_nanos_i});
  assign mag      = sec_neg1 ? err_pos : $signed({1'b0, offset_nanos_i});
  assign err      = sec_neg1 ? err_pos : err_neg;
  assign do_step  = !(sec_zero || sec_neg1) || (mag > $signed({1'b0, cfg_i.thr}));

  assign p_term  = err * $signed({1'b0, cfg_i.gain_p});
  assign i_term  = err * $signed({1'b0, cfg_i.gain_i});
  assign acc_raw = integ_q + i_term;
  assign lim_s   = $signed(ACC_W'(cfg_i.lim));

  always_comb begin
    priority if (acc_raw > lim_s) begin
      acc_sat = lim_s;
    end else if (acc_raw < -lim_s) begin
      acc_sat = -lim_s;
    end else begin
      acc_sat = acc_raw;
    end
  end

  assign total     = p_term + acc_sat;
  assign total_hi  = total[ACC_W-1:FRAC_W-1];
  assign total_ovf = !((&total_hi) || !(|total_hi));

  always_comb begin
    res_o.do_step = do_step;
    if (total_ovf) begin
      res_o.fraction = total[ACC_W-1] ? {1'b1, {(FRAC_W-1){1'b0}}}
                                      : {1'b0, {(FRAC_W-1){1'b1}}};
    end else begin
      res_o.fraction = total[FRAC_W-1:0];
    end
  end

  // clear on step, otherwise take the clamped sum
  assign integ_d = do_step ? '0 : acc_sat[INTEG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (adv_i) begin
      integ_q <= integ_d;
    end
  end

  a_step_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && do_step |=> integ_q == '0)
    else $error("integral not cleared after step");

endmodule
